// ----- design/assert_macros.svh -----
// Assertion macros shared by the accumulator RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/cfa_pkg.sv -----
// Shared types, constants and helpers for the compensated accumulator.
// No dependencies.
`default_nettype none
package cfa_pkg;

  // Canonical quiet NaN and binary64 exponent of all ones
  localparam logic [63:0] QNAN_BITS = 64'h7FF8000000000000;
  localparam logic [10:0] EXP_MAX   = 11'h7FF;

  // Queue word between front and back
  typedef struct packed {
    logic [63:0] sample;
    logic        restart;
    logic        rejected;
  } cfa_item_t;

  // Operand pair for the shared adder
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
  } cfa_add_req_t;

  function automatic logic f64_not_finite(input logic [63:0] x);
    return &x[62:52];
  endfunction

  function automatic logic [63:0] f64_neg(input logic [63:0] x);
    return {~x[63], x[62:0]};
  endfunction

endpackage
`default_nettype wire

// ----- design/compensated_float_accumulator.sv -----
// Top level of the Neumaier compensated binary64 accumulator.
// Instantiates cfa_front, cfa_fadd and cfa_back; uses cfa_pkg.
//
//   channel  handshake                   words
//   sample   sample_valid/sample_ready   sample_bits, restart
//   total    total_valid/total_ready     total_bits, rejected, total_not_finite
//
// An accepted sample runs through the back end as a pop step, five dependent adds
// (each through the two-stage shared adder) and a load of the output register;
// a rejected sample skips to the final add of sum and correction.
// The single shared adder sets the rate.
// A two-word queue keeps samples flowing while the back end works.
// Reset (rst, synchronous) clears the sum and correction to +0 and empties
// the queue. A stalled result waits in the output register.
`default_nettype none
module compensated_float_accumulator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        sample_valid,
  output logic             sample_ready,
  input  wire logic [63:0] sample_bits,
  input  wire logic        restart,
  output logic             total_valid,
  input  wire logic        total_ready,
  output logic [63:0]      total_bits,
  output logic             rejected,
  output logic             total_not_finite
);
  import cfa_pkg::*;

  logic         q_valid, q_pop, req_valid, res_valid;
  cfa_item_t    q_item;
  cfa_add_req_t req;
  logic [63:0]  res;

  cfa_front u_front (
    .clk, .rst, .sample_valid, .sample_ready, .sample_bits, .restart,
    .q_valid, .q_item, .q_pop
  );

  cfa_fadd u_fadd (
    .clk, .rst, .in_valid(req_valid), .req, .out_valid(res_valid), .out_sum(res)
  );

  cfa_back u_back (
    .clk, .rst, .q_valid, .q_item, .q_pop, .req_valid, .req, .res_valid, .res,
    .total_valid, .total_ready, .total_bits, .rejected, .total_not_finite
  );

endmodule
`default_nettype wire

// ----- design/cfa_fadd.sv -----
// Two-stage binary64 adder, round to nearest even, subnormals kept.
// Stage one aligns and adds, stage two normalizes and rounds. Uses cfa_pkg.
`default_nettype none
`include "assert_macros.svh"
module cfa_fadd (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire cfa_pkg::cfa_add_req_t req,
  output logic                       out_valid,
  output logic [63:0]                out_sum
);
  import cfa_pkg::*;

  logic        a_nan, b_nan, a_inf, b_inf, swap;
  logic [63:0] x, y;
  logic [10:0] ex, ey, diff;
  logic [52:0] mx, my;
  logic [55:0] mx_ext, my_ext, my_al, lost_mask;
  logic [56:0] sum_c;

  // Stage one: unpack, order by magnitude, align, add
  always_comb begin
    a_nan  = (req.a[62:52] == EXP_MAX) && (req.a[51:0] != 52'd0);
    b_nan  = (req.b[62:52] == EXP_MAX) && (req.b[51:0] != 52'd0);
    a_inf  = (req.a[62:52] == EXP_MAX) && (req.a[51:0] == 52'd0);
    b_inf  = (req.b[62:52] == EXP_MAX) && (req.b[51:0] == 52'd0);
    swap   = req.a[62:0] < req.b[62:0];
    x      = swap ? req.b : req.a;
    y      = swap ? req.a : req.b;
    ex     = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
    ey     = (y[62:52] == 11'd0) ? 11'd1 : y[62:52];
    mx     = {(x[62:52] != 11'd0), x[51:0]};
    my     = {(y[62:52] != 11'd0), y[51:0]};
    diff   = ex - ey;
    mx_ext = {mx, 3'b000};
    my_ext = {my, 3'b000};
    lost_mask = ~({56{1'b1}} << diff[5:0]);
    if (diff >= 11'd56) begin
      my_al = {55'd0, (my != 53'd0)};
    end else begin
      my_al = (my_ext >> diff[5:0]) | {55'd0, ((my_ext & lost_mask) != 56'd0)};
    end
    if (x[63] ^ y[63]) begin
      sum_c = {1'b0, mx_ext} - {1'b0, my_al};
    end else begin
      sum_c = {1'b0, mx_ext} + {1'b0, my_al};
    end
  end

  logic        s1_valid, s1_sign, s1_zsign, s1_nan, s1_inf, s1_isign;
  logic [10:0] s1_exp;
  logic [56:0] s1_sum;

  // Hold stage one results
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_sum   <= sum_c;
    s1_exp   <= ex;
    s1_sign  <= x[63];
    s1_zsign <= req.a[63] & req.b[63];
    s1_nan   <= a_nan | b_nan | (a_inf & b_inf & (req.a[63] != req.b[63]));
    s1_inf   <= a_inf | b_inf;
    s1_isign <= a_inf ? req.a[63] : req.b[63];
  end

  logic [5:0]  lz, sh;
  logic        found;
  logic [10:0] limit;
  logic [55:0] m;
  logic [11:0] e, field;
  logic        inc;
  logic [53:0] mr;
  logic [51:0] frac;
  logic [63:0] res;

  // Stage two: normalize, round, pack
  always_comb begin
    lz    = 6'd56;
    found = 1'b0;
    for (int i = 55; i >= 0; i--) begin
      if (!found && s1_sum[i]) begin
        lz    = 6'(55 - i);
        found = 1'b1;
      end
    end
    limit = s1_exp - 11'd1;
    sh    = ({5'd0, lz} > limit) ? limit[5:0] : lz;
    if (s1_sum[56]) begin
      m = {s1_sum[56:2], s1_sum[1] | s1_sum[0]};
      e = {1'b0, s1_exp} + 12'd1;
    end else begin
      m = s1_sum[55:0] << sh;
      e = {1'b0, s1_exp} - {6'd0, sh};
    end
    inc   = m[2] & (m[1] | m[0] | m[3]);
    mr    = {1'b0, m[55:3]} + {53'd0, inc};
    field = mr[53] ? (e + 12'd1) : (mr[52] ? e : 12'd0);
    frac  = mr[53] ? 52'd0 : mr[51:0];
    if (s1_nan) begin
      res = QNAN_BITS;
    end else if (s1_inf) begin
      res = {s1_isign, EXP_MAX, 52'd0};
    end else if (s1_sum == 57'd0) begin
      res = {s1_zsign, 63'd0};
    end else if (field >= {1'b0, EXP_MAX}) begin
      res = {s1_sign, EXP_MAX, 52'd0};
    end else begin
      res = {s1_sign, field[10:0], frac};
    end
  end

  // Hold the packed sum
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_valid;
    end
    out_sum <= res;
  end

  `ASSERT_ALWAYS(a_fadd_latency, !out_valid || $past(in_valid, 2), "adder result without request")

endmodule
`default_nettype wire

// ----- design/cfa_front.sv -----
// Front end: takes input words, flags non-finite samples, queues them.
// Two-word queue toward the back end. Uses cfa_pkg.
`default_nettype none
`include "assert_macros.svh"
module cfa_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               sample_valid,
  output logic                    sample_ready,
  input  wire logic [63:0]        sample_bits,
  input  wire logic               restart,
  output logic                    q_valid,
  output cfa_pkg::cfa_item_t      q_item,
  input  wire logic               q_pop
);
  import cfa_pkg::*;

  cfa_item_t  slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign sample_ready = (count != 2'd2);
  assign push         = sample_valid & sample_ready;
  assign pop          = q_pop & (count != 2'd0);
  assign q_valid      = (count != 2'd0);
  assign q_item       = slots[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Store the classified word
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{sample: sample_bits, restart: restart,
                         rejected: f64_not_finite(sample_bits)};
    end
  end

  `ASSERT_ALWAYS(a_queue_bound, count <= 2'd2, "queue count out of range")

endmodule
`default_nettype wire

// ----- design/cfa_back.sv -----
// Back end: sequences the Neumaier update through the shared adder
// and holds the result word. Uses cfa_pkg and cfa_fadd's request format.
`default_nettype none
`include "assert_macros.svh"
module cfa_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  input  wire cfa_pkg::cfa_item_t    q_item,
  output logic                       q_pop,
  output logic                       req_valid,
  output cfa_pkg::cfa_add_req_t      req,
  input  wire logic                  res_valid,
  input  wire logic [63:0]           res,
  output logic                       total_valid,
  input  wire logic                  total_ready,
  output logic [63:0]                total_bits,
  output logic                       rejected,
  output logic                       total_not_finite
);
  import cfa_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SUM   = 3'd1;
  localparam logic [2:0] ST_DIFF  = 3'd2;
  localparam logic [2:0] ST_ERR   = 3'd3;
  localparam logic [2:0] ST_CORR  = 3'd4;
  localparam logic [2:0] ST_TOTAL = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]  step;
  logic        waiting;
  logic [63:0] run_sum, corr, val, t_reg, d_reg, tot;
  logic        item_rej, sum_big;

  assign q_pop   = (step == ST_IDLE) && q_valid;
  assign sum_big = run_sum[62:0] >= val[62:0];

  // Pick operands for the current step
  always_comb begin
    req_valid = 1'b0;
    req       = '{a: run_sum, b: corr};
    case (step)
      ST_SUM: begin
        req_valid = !waiting;
        req       = '{a: run_sum, b: val};
      end
      ST_DIFF: begin
        req_valid = !waiting;
        req       = '{a: (sum_big ? run_sum : val), b: f64_neg(t_reg)};
      end
      ST_ERR: begin
        req_valid = !waiting;
        req       = '{a: d_reg, b: (sum_big ? val : run_sum)};
      end
      ST_CORR: begin
        req_valid = !waiting;
        req       = '{a: corr, b: d_reg};
      end
      ST_TOTAL: begin
        req_valid = !waiting;
        req       = '{a: run_sum, b: corr};
      end
      default: begin
        req_valid = 1'b0;
      end
    endcase
  end

  // Advance the sequence and commit state
  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= ST_IDLE;
      waiting     <= 1'b0;
      run_sum     <= 64'd0;
      corr        <= 64'd0;
      total_valid <= 1'b0;
    end else begin
      // drop the taken word unless a new one loads in the same cycle
      if (total_valid && total_ready && (step != ST_DONE)) total_valid <= 1'b0;
      if (req_valid) waiting <= 1'b1;
      case (step)
        ST_IDLE: begin
          if (q_valid) begin
            val      <= q_item.sample;
            item_rej <= q_item.rejected;
            if (!q_item.rejected && q_item.restart) begin
              run_sum <= 64'd0;
              corr    <= 64'd0;
            end
            step <= q_item.rejected ? ST_TOTAL : ST_SUM;
          end
        end
        ST_SUM: if (res_valid) begin
          t_reg <= res; waiting <= 1'b0; step <= ST_DIFF;
        end
        ST_DIFF: if (res_valid) begin
          d_reg <= res; waiting <= 1'b0; step <= ST_ERR;
        end
        ST_ERR: if (res_valid) begin
          d_reg <= res; waiting <= 1'b0; step <= ST_CORR;
        end
        ST_CORR: if (res_valid) begin
          run_sum <= t_reg; corr <= res; waiting <= 1'b0; step <= ST_TOTAL;
        end
        ST_TOTAL: if (res_valid) begin
          tot <= res; waiting <= 1'b0; step <= ST_DONE;
        end
        ST_DONE: begin
          if (!total_valid || total_ready) begin
            total_valid      <= 1'b1;
            total_bits       <= tot;
            rejected         <= item_rej;
            total_not_finite <= f64_not_finite(tot);
            step             <= ST_IDLE;
          end
        end
        default: step <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_res_expected, !res_valid || waiting, "adder result while not waiting")
  `ASSERT_NEXT(a_pop_leaves_idle, q_pop, step != ST_IDLE, "popped word not started")

endmodule
`default_nettype wire
